[hw/rtl/jsi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsi_pkg: shared types and constants of the joint slew interpolator
// Request codes, register indexes, fixed-point constants and saturation.
// ----------------------------------------------------------------------------
package jsi_pkg;

  // request codes
  localparam logic [1:0] REQ_RESET  = 2'd0;
  localparam logic [1:0] REQ_TARGET = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_VEL = 2'd0;
  localparam logic [1:0] CFG_MAX_ACC = 2'd1;
  localparam logic [1:0] CFG_ACC_EN  = 2'd2;

  // microseconds per second and the rounding offset for the dt scaling
  localparam int unsigned US_PER_S   = 1000000;
  localparam int unsigned ROUND_HALF = 500000;

  // floor(2^48 / 1e6): reciprocal for the quotient estimate
  localparam logic [31:0] DIV_RECIP = 32'd281474976;

  // quotient bits of a dt scaling (product below 2^28 * 1e6)
  localparam int unsigned QW = 28;

  // operation tags of the shared multiply/divide path
  localparam logic [1:0] TAG_LIM = 2'd0;
  localparam logic [1:0] TAG_DVL = 2'd1;
  localparam logic [1:0] TAG_POS = 2'd2;
  localparam logic [1:0] TAG_SQ  = 2'd3;

  // one joint entry in the state memory
  typedef struct packed {
    logic [31:0] cmd;
    logic [31:0] vel;
    logic [31:0] tgt;
  } joint_entry_t;

  // saturate a 34-bit signed value to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) r = 32'h7FFF_FFFF;
    else if (v < -34'sh0_8000_0000) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

[hw/rtl/joint_slew_interpolator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_slew_interpolator_top: per-joint Q16.16 setpoint generator
// Velocity slew or velocity/acceleration limited profile for NUM_JOINTS joints.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_stall. A reset request loads one joint's
// command and target directly; a set-target request on an initialized
// joint reads the entry, then writes it back. A tick request walks all joints
// in order and sends one result per joint on out_valid/out_stall, the last one
// flagged by out_last_joint. in_stall stays high until the request is done.
// Tick: with a nonzero dt, the step and velocity change limits are computed
// once (two passes of multiply, rounding offset, reciprocal multiply, back
// multiply and correction). Per joint: a short path when idle, uninitialized
// or in pure slew; the acceleration mode adds the 32-step square root and
// the divide by 1e6, both run on one shared multiplier. Joint state lives in
// one memory with registered read data, read once per joint and written
// back at most once per joint.
// A held output stalls the sequencer in place; nothing is lost.
// Reset (rst_n low, synchronous) restores the register defaults and marks all
// joints uninitialized; uninitialized joints read as zero. Configuration writes
// on cfg_we take effect at once; the user must write while idle (not enforced).
// ----------------------------------------------------------------------------
module joint_slew_interpolator_top #(
  parameter int NUM_JOINTS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic [2:0]         in_joint_index,
  input  logic signed [31:0] in_position,
  input  logic [15:0]        in_dt_us,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_out_joint,
  output logic signed [31:0] out_command_position,
  output logic               out_last_joint,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_wdata
);

  localparam int AW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam logic [AW-1:0] LAST_J = AW'(NUM_JOINTS - 1);
  localparam int QW = jsi_pkg::QW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TGT  = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_DINI = 4'd3;
  localparam logic [3:0] S_RCP  = 4'd4;
  localparam logic [3:0] S_SQI  = 4'd5;
  localparam logic [3:0] S_SQRT = 4'd6;
  localparam logic [3:0] S_VEL  = 4'd7;
  localparam logic [3:0] S_POS  = 4'd8;
  localparam logic [3:0] S_RD   = 4'd9;
  localparam logic [3:0] S_EVAL = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;
  localparam logic [3:0] S_BAK  = 4'd12;
  localparam logic [3:0] S_FIX  = 4'd13;

  logic [3:0]            state_r;
  logic [30:0]           max_vel_r;
  logic [30:0]           max_acc_r;
  logic                  acc_en_r;
  logic [NUM_JOINTS-1:0] ready_r;
  logic [AW-1:0]         j_r;
  logic [15:0]           dt_r;
  logic [1:0]            tag_r;
  logic [63:0]           prod_r;
  logic [47:0]           n_r;
  logic [31:0]           qe_r;
  logic [QW-1:0]         q_r;
  logic [4:0]            cnt_r;
  logic [63:0]           x_r;
  logic [33:0]           srem_r;
  logic [31:0]           root_r;
  logic [QW-1:0]         lim_r;
  logic [QW-1:0]         dvlim_r;
  logic [31:0]           cmd_r;
  logic [31:0]           vel_r;
  logic [31:0]           tgt_r;
  logic                  neg_r;
  logic [31:0]           mag_r;
  logic [31:0]           res_cmd_r;
  logic [31:0]           res_vel_r;
  logic                  wr_r;
  logic [AW-1:0]         tgt_idx_r;
  logic [31:0]           tgt_pos_r;
  logic                  out_valid_r;
  logic [2:0]            out_joint_r;
  logic [31:0]           out_cmd_r;
  logic                  out_last_r;

  logic                  accept;
  logic                  idx_ok;
  logic [AW-1:0]         in_addr;
  logic                  accel_mode;
  logic                  out_free;

  // ports
  assign in_stall             = (state_r != S_IDLE);
  assign accept               = in_valid && !in_stall;
  assign out_valid            = out_valid_r;
  assign out_out_joint        = out_joint_r;
  assign out_command_position = out_cmd_r;
  assign out_last_joint       = out_last_r;

  assign idx_ok     = ({29'd0, in_joint_index} < 32'(NUM_JOINTS));
  assign in_addr    = AW'(in_joint_index);
  assign accel_mode = acc_en_r && (max_acc_r != 31'd0);
  assign out_free   = !out_valid_r || !out_stall;

  // state memory
  logic                  mem_we;
  logic [AW-1:0]         mem_wa;
  jsi_pkg::joint_entry_t mem_wd;
  logic [AW-1:0]         mem_ra;
  jsi_pkg::joint_entry_t mem_rd;
  jsi_pkg::joint_entry_t ent;

  assign mem_ra = (state_r == S_IDLE) ? in_addr : j_r;
  assign ent    = ready_r[j_r] ? mem_rd : '0;

  jsi_ram #(
    .WIDTH ($bits(jsi_pkg::joint_entry_t)),
    .DEPTH (NUM_JOINTS)
  ) u_state_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_wa),
    .wdata (mem_wd),
    .raddr (mem_ra),
    .rdata (mem_rd)
  );

  // select memory write
  always_comb begin
    mem_we = 1'b0;
    mem_wa = j_r;
    mem_wd = '0;
    if (state_r == S_IDLE) begin
      if (accept && idx_ok && (in_req_type == jsi_pkg::REQ_RESET ||
          (in_req_type == jsi_pkg::REQ_TARGET && !ready_r[in_addr]))) begin
        mem_we = 1'b1;
        mem_wa = in_addr;
        mem_wd = '{cmd: in_position, vel: 32'd0, tgt: in_position};
      end
    end else if (state_r == S_TGT) begin
      mem_we = 1'b1;
      mem_wa = tgt_idx_r;
      mem_wd = '{cmd: mem_rd.cmd, vel: mem_rd.vel, tgt: tgt_pos_r};
    end else if (state_r == S_OUT) begin
      mem_we = out_free && wr_r;
      mem_wd = '{cmd: res_cmd_r, vel: res_vel_r, tgt: tgt_r};
    end
  end

  // shared multiplier operands
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  always_comb begin
    if (state_r == S_RCP) begin
      mul_a = n_r[47:16];
      mul_b = jsi_pkg::DIV_RECIP;
    end else if (state_r == S_BAK) begin
      mul_a = qe_r;
      mul_b = 32'(jsi_pkg::US_PER_S);
    end else begin
      case (tag_r)
        jsi_pkg::TAG_LIM: begin
          mul_a = {1'b0, max_vel_r};
          mul_b = {16'd0, dt_r};
        end
        jsi_pkg::TAG_DVL: begin
          mul_a = {1'b0, max_acc_r};
          mul_b = {16'd0, dt_r};
        end
        jsi_pkg::TAG_SQ: begin
          mul_a = {1'b0, max_acc_r};
          mul_b = mag_r;
        end
        default: begin
          mul_a = mag_r;
          mul_b = {16'd0, dt_r};
        end
      endcase
    end
  end

  assign mul_p = mul_a * mul_b;

  // divide by 1e6: rounding offset, reciprocal estimate, one correction
  logic [47:0] div_n;
  logic [47:0] fix_rem;
  logic [31:0] q_fix;

  assign div_n   = prod_r[47:0] + 48'(jsi_pkg::ROUND_HALF);
  assign fix_rem = n_r - prod_r[47:0];
  assign q_fix   = qe_r + ((fix_rem >= 48'(jsi_pkg::US_PER_S)) ? 32'd1 : 32'd0);

  // square root: one result bit per cycle
  logic [35:0] sq_t;
  logic [35:0] sq_trial;
  logic        sq_ge;
  logic [35:0] sq_d;
  logic [33:0] srem_nxt;

  assign sq_t     = {srem_r, x_r[63:62]};
  assign sq_trial = {2'b00, root_r, 2'b01};
  assign sq_ge    = (sq_t >= sq_trial);
  assign sq_d     = sq_t - sq_trial;
  assign srem_nxt = sq_ge ? sq_d[33:0] : sq_t[33:0];

  // evaluate a joint: distance and pure slew step
  logic signed [32:0] gap;
  logic signed [32:0] lim_s;
  logic signed [32:0] slew_cl;
  logic [32:0]        gap_abs;
  logic [31:0]        slew_cmd;

  assign gap     = $signed({ent.tgt[31], ent.tgt}) - $signed({ent.cmd[31], ent.cmd});
  assign lim_s   = $signed({5'd0, lim_r});
  assign gap_abs = gap[32] ? 33'(-gap) : 33'(gap);

  always_comb begin
    if (gap > lim_s) slew_cl = lim_s;
    else if (gap < -lim_s) slew_cl = -lim_s;
    else slew_cl = gap;
  end

  assign slew_cmd = jsi_pkg::sat32($signed({{2{ent.cmd[31]}}, ent.cmd}) +
                                   $signed({slew_cl[32], slew_cl}));

  // velocity update from the desired speed
  logic [31:0]        speed;
  logic signed [33:0] desired;
  logic signed [33:0] dv;
  logic signed [33:0] dvl_s;
  logic signed [33:0] dv_cl;
  logic [31:0]        nv;
  logic [32:0]        nv_abs;

  assign speed   = (root_r > {1'b0, max_vel_r}) ? {1'b0, max_vel_r} : root_r;
  assign desired = neg_r ? -$signed({2'b00, speed}) : $signed({2'b00, speed});
  assign dv      = desired - $signed({{2{vel_r[31]}}, vel_r});
  assign dvl_s   = $signed({6'd0, dvlim_r});

  always_comb begin
    if (dv > dvl_s) dv_cl = dvl_s;
    else if (dv < -dvl_s) dv_cl = -dvl_s;
    else dv_cl = dv;
  end

  assign nv     = jsi_pkg::sat32($signed({{2{vel_r[31]}}, vel_r}) + dv_cl);
  assign nv_abs = nv[31] ? 33'(-$signed({nv[31], nv})) : {1'b0, nv};

  // position step from the new velocity
  logic signed [33:0] inc;
  logic [31:0]        pos_cmd;

  assign inc     = neg_r ? -$signed({6'd0, q_r}) : $signed({6'd0, q_r});
  assign pos_cmd = jsi_pkg::sat32($signed({{2{cmd_r[31]}}, cmd_r}) + inc);

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_vel_r   <= 31'd3932160;
      max_acc_r   <= 31'd19660800;
      acc_en_r    <= 1'b1;
      ready_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // hold configuration
      if (cfg_we) begin
        unique case (cfg_index)
          jsi_pkg::CFG_MAX_VEL: max_vel_r <= cfg_wdata;
          jsi_pkg::CFG_MAX_ACC: max_acc_r <= cfg_wdata;
          jsi_pkg::CFG_ACC_EN:  acc_en_r  <= cfg_wdata[0];
          default: ;
        endcase
      end

      // drop a taken result
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            unique case (in_req_type) inside
              jsi_pkg::REQ_RESET, jsi_pkg::REQ_TARGET: begin
                if (idx_ok) begin
                  if (in_req_type == jsi_pkg::REQ_RESET || !ready_r[in_addr]) begin
                    ready_r[in_addr] <= 1'b1;
                  end else begin
                    tgt_idx_r <= in_addr;
                    tgt_pos_r <= in_position;
                    state_r   <= S_TGT;
                  end
                end
              end
              jsi_pkg::REQ_TICK: begin
                dt_r <= in_dt_us;
                j_r  <= '0;
                if (in_dt_us != 16'd0) begin
                  tag_r   <= jsi_pkg::TAG_LIM;
                  state_r <= S_MUL;
                end else begin
                  state_r <= S_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_TGT: begin
          state_r <= S_IDLE;
        end
        S_MUL: begin
          prod_r  <= mul_p;
          state_r <= (tag_r == jsi_pkg::TAG_SQ) ? S_SQI : S_DINI;
        end
        S_DINI: begin
          n_r     <= div_n;
          state_r <= S_RCP;
        end
        S_RCP: begin
          qe_r    <= mul_p[63:32];
          state_r <= S_BAK;
        end
        S_BAK: begin
          prod_r  <= mul_p;
          state_r <= S_FIX;
        end
        S_FIX: begin
          case (tag_r)
            jsi_pkg::TAG_LIM: begin
              lim_r   <= q_fix[QW-1:0];
              tag_r   <= jsi_pkg::TAG_DVL;
              state_r <= S_MUL;
            end
            jsi_pkg::TAG_DVL: begin
              dvlim_r <= q_fix[QW-1:0];
              state_r <= S_RD;
            end
            default: begin
              q_r     <= q_fix[QW-1:0];
              state_r <= S_POS;
            end
          endcase
        end
        S_SQI: begin
          x_r     <= {prod_r[62:0], 1'b0};
          srem_r  <= '0;
          root_r  <= '0;
          cnt_r   <= '0;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          x_r    <= {x_r[61:0], 2'b00};
          srem_r <= srem_nxt;
          root_r <= {root_r[30:0], sq_ge};
          cnt_r  <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            state_r <= S_VEL;
          end
        end
        S_VEL: begin
          vel_r   <= nv;
          mag_r   <= nv_abs[31:0];
          neg_r   <= nv[31];
          tag_r   <= jsi_pkg::TAG_POS;
          state_r <= S_MUL;
        end
        S_POS: begin
          res_cmd_r <= pos_cmd;
          res_vel_r <= vel_r;
          wr_r      <= 1'b1;
          state_r   <= S_OUT;
        end
        S_RD: begin
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          cmd_r <= ent.cmd;
          vel_r <= ent.vel;
          tgt_r <= ent.tgt;
          if (dt_r == 16'd0 || !ready_r[j_r]) begin
            res_cmd_r <= ent.cmd;
            wr_r      <= 1'b0;
            state_r   <= S_OUT;
          end else if (!accel_mode) begin
            res_cmd_r <= slew_cmd;
            res_vel_r <= 32'd0;
            wr_r      <= 1'b1;
            state_r   <= S_OUT;
          end else begin
            mag_r   <= gap_abs[31:0];
            neg_r   <= gap[32];
            tag_r   <= jsi_pkg::TAG_SQ;
            state_r <= S_MUL;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_joint_r <= 3'(j_r);
            out_cmd_r   <= res_cmd_r;
            out_last_r  <= (j_r == LAST_J);
            if (j_r == LAST_J) begin
              state_r <= S_IDLE;
            end else begin
              j_r     <= j_r + 1'b1;
              state_r <= S_RD;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside the output step");

  a_last_joint: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_joint_r == 3'(NUM_JOINTS - 1)))
    else $error("last flag on a joint other than the final one");

  a_div_fix: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIX) |-> (fix_rem < 48'(2 * jsi_pkg::US_PER_S)))
    else $error("quotient estimate off by more than one");

endmodule

[hw/rtl/jsi_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsi_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module jsi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
